// ----- rtl/multi_waveform_oscillator_macros.svh -----
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef MULTI_WAVEFORM_OSCILLATOR_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_MACROS_SVH

// Same-cycle implication.
`define MWO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MWO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mwo_pkg.sv -----
`default_nettype none
package mwo_pkg;

  typedef enum logic [1:0] {
    WaveSquare = 2'd0,
    WaveSaw    = 2'd1,
    WaveTri    = 2'd2,
    WaveSine   = 2'd3
  } wave_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] volume;
    wave_e      wave;
  } side_t;

  localparam int unsigned SampleRate   = 16000;
  localparam int unsigned PeriodDen    = 16 * SampleRate;
  localparam int unsigned HalfPeriod   = PeriodDen / 2;
  localparam int unsigned QuarterPer   = PeriodDen / 4;
  localparam int unsigned ThreeQtrPer  = 3 * (PeriodDen / 4);

  // period = 2^11 * 125; residue folding constants 2^k mod 125
  localparam int unsigned ResMod   = 125;
  localparam int unsigned Fold1Mul = 19;
  localparam int unsigned Fold2Mul = 96;
  localparam int unsigned Fold3Mul = 24;
  localparam int unsigned Fold4Mul = 3;

  // floor(x / 125) = (x * Recip) >> Shift over the used ranges
  localparam int unsigned TriRecip = 67109;
  localparam int unsigned TriShift = 23;
  localparam int unsigned AngMul   = 3217;
  localparam int unsigned AngRecip = 8589935;
  localparam int unsigned AngShift = 30;

  localparam int unsigned C0Q15 = 32758;
  localparam int unsigned C1Q15 = 5416;
  localparam int unsigned C2Q15 = 241;

  localparam int unsigned PhaseStages = 4;
  localparam int unsigned SineStages  = 9;
  localparam int unsigned Latency     = PhaseStages + SineStages;

endpackage
`default_nettype wire

// ----- rtl/mwo_phase.sv -----
`default_nettype none
`include "multi_waveform_oscillator_macros.svh"
module mwo_phase (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mwo_pkg::side_t side_i,
  input  logic [30:0]    sample_time_i,
  input  logic [15:0]    pitch_i,
  output mwo_pkg::side_t side_o,
  output logic [17:0]    resid_o
);

  mwo_pkg::side_t side_q [mwo_pkg::PhaseStages];

  logic [46:0] prod_d, prod_q;
  logic [22:0] fold1_d, fold1_q;
  logic [17:0] fold2;
  logic [12:0] fold3_d, fold3_q;
  logic [8:0]  fold4, res9;
  logic [10:0] low2_q, low3_q;
  logic [17:0] resid_d, resid_q;

  assign prod_d  = 47'(sample_time_i) * 47'(pitch_i);
  assign fold1_d = 23'(prod_q[46:29]) * 23'(mwo_pkg::Fold1Mul) + 23'(prod_q[28:11]);
  assign fold2   = 18'(fold1_q[22:12]) * 18'(mwo_pkg::Fold2Mul) + 18'(fold1_q[11:0]);
  assign fold3_d = 13'(fold2[17:10]) * 13'(mwo_pkg::Fold3Mul) + 13'(fold2[9:0]);
  assign fold4   = 9'(fold3_q[12:7]) * 9'(mwo_pkg::Fold4Mul) + 9'(fold3_q[6:0]);

  always_comb begin
    if (fold4 >= 9'(2 * mwo_pkg::ResMod)) begin
      res9 = fold4 - 9'(2 * mwo_pkg::ResMod);
    end else if (fold4 >= 9'(mwo_pkg::ResMod)) begin
      res9 = fold4 - 9'(mwo_pkg::ResMod);
    end else begin
      res9 = fold4;
    end
  end

  assign resid_d = {res9[6:0], low3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mwo_pkg::PhaseStages; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side_i;
      for (int i = 1; i < mwo_pkg::PhaseStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    fold1_q <= fold1_d;
    low2_q  <= prod_q[10:0];
    fold3_q <= fold3_d;
    low3_q  <= low2_q;
    resid_q <= resid_d;
  end

  assign side_o  = side_q[mwo_pkg::PhaseStages-1];
  assign resid_o = resid_q;

  `MWO_ASSERT_IMP(a_resid_range, side_o.valid, resid_o < 18'(mwo_pkg::PeriodDen), "residue out of range")

endmodule
`default_nettype wire

// ----- rtl/mwo_sine.sv -----
`default_nettype none
`include "multi_waveform_oscillator_macros.svh"
module mwo_sine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwo_pkg::side_t     side_i,
  input  logic [17:0]        resid_i,
  output mwo_pkg::side_t     side_o,
  output logic signed [8:0]  sine_o
);

  mwo_pkg::side_t side_q [mwo_pkg::SineStages];
  logic           sgn_q  [mwo_pkg::SineStages];

  logic [17:0] diff;
  logic [15:0] mag_d, mag_q;
  logic        neg, odd;
  logic [27:0] angp_q;
  logic [46:0] angd_q;
  logic [15:0] r1_q, r2_q, r3_q;
  logic [31:0] rsq_q;
  logic [16:0] y_q;
  logic [24:0] c2y_q;
  logic [12:0] z1abs;
  logic [29:0] z1y_q;
  logic [15:0] z2;
  logic [30:0] rz_q;
  logic [23:0] sv_q;
  logic [8:0]  o9, m9;
  logic [7:0]  mag8;
  logic [8:0]  sine_d;
  logic signed [8:0] sine_q;

  // fold the residue to its distance from the nearest multiple of a half period (0 to a quarter period)
  always_comb begin
    if (resid_i < 18'(mwo_pkg::QuarterPer)) begin
      diff = resid_i;
      neg  = 1'b0;
      odd  = 1'b0;
    end else if (resid_i < 18'(mwo_pkg::HalfPeriod)) begin
      diff = 18'(mwo_pkg::HalfPeriod) - resid_i;
      neg  = 1'b1;
      odd  = 1'b1;
    end else if (resid_i < 18'(mwo_pkg::ThreeQtrPer)) begin
      diff = resid_i - 18'(mwo_pkg::HalfPeriod);
      neg  = 1'b0;
      odd  = 1'b1;
    end else begin
      diff = 18'(mwo_pkg::PeriodDen) - resid_i;
      neg  = 1'b1;
      odd  = 1'b0;
    end
  end

  assign mag_d = diff[15:0];
  assign z1abs = 13'(mwo_pkg::C1Q15) - 13'(c2y_q[24:15]);
  assign z2    = 16'(mwo_pkg::C0Q15) - 16'(z1y_q[29:15]);
  assign o9    = sv_q[23:15];
  assign mag8  = (o9 > 9'd255) ? 8'hFF : o9[7:0];
  assign m9    = {1'b0, mag8};
  assign sine_d = sgn_q[mwo_pkg::SineStages-2] ? (~m9 + 9'd1) : m9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mwo_pkg::SineStages; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side_i;
      for (int i = 1; i < mwo_pkg::SineStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q[0] <= neg ^ odd;
    for (int i = 1; i < mwo_pkg::SineStages; i++) begin
      sgn_q[i] <= sgn_q[i-1];
    end
    mag_q  <= mag_d;
    angp_q <= 28'(mag_q) * 28'(mwo_pkg::AngMul);
    angd_q <= 47'(angp_q[27:5]) * 47'(mwo_pkg::AngRecip);
    r1_q   <= angd_q[45:mwo_pkg::AngShift];
    rsq_q  <= 32'(angd_q[45:mwo_pkg::AngShift]) * 32'(angd_q[45:mwo_pkg::AngShift]);
    r2_q   <= r1_q;
    y_q    <= rsq_q[31:15];
    c2y_q  <= 25'(rsq_q[31:15]) * 25'(mwo_pkg::C2Q15);
    r3_q   <= r2_q;
    z1y_q  <= 30'(z1abs) * 30'(y_q);
    rz_q   <= 31'(r3_q) * 31'(z2);
    sv_q   <= 24'(rz_q[30:15]) * 24'(side_q[mwo_pkg::SineStages-3].volume);
    sine_q <= $signed(sine_d);
  end

  assign side_o = side_q[mwo_pkg::SineStages-1];
  assign sine_o = sine_q;

  `MWO_ASSERT_IMP(a_mute, side_o.valid && side_o.volume == 8'd0, sine_o == 9'sd0, "sine not muted at zero volume")

endmodule
`default_nettype wire

// ----- rtl/multi_waveform_oscillator.sv -----
// A request taken at a clock edge gives its sample at the end of the pipeline, with done_o high.
// Throughput: one request per cycle; busy_o stays low, the 13-stage pipeline never stalls.
// Period residue by constant folding (4 stages), then 9 stages of sine polynomial; square, saw and
// triangle are computed beside it from the residue. Reset (rst_ni low, asynchronous) clears the
// stage valid bits; no sample follows a request that was in flight at reset.
`default_nettype none
`include "multi_waveform_oscillator_macros.svh"
module multi_waveform_oscillator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [30:0]       sample_time_i,
  input  logic [15:0]       pitch_i,
  input  logic [7:0]        volume_i,
  input  logic [1:0]        wave_type_i,
  output logic              busy_o,
  output logic              done_o,
  output logic signed [8:0] sample_value_o
);

  localparam int unsigned DlyDepth = mwo_pkg::SineStages - 2;

  mwo_pkg::side_t side_in, ph_side, sn_side;
  logic [17:0]    ph_resid;
  logic signed [8:0] sn_value;

  logic [7:0]     vol5_q, vol6_q;
  mwo_pkg::wave_e wave5_q, wave6_q;
  logic [25:0]    rv_q;
  logic [32:0]    tprod;
  logic [9:0]     t_q;
  logic [8:0]     saw;
  logic [7:0]     nsw_d;
  logic [7:0]     dly_q [DlyDepth];

  assign busy_o  = 1'b0;
  assign side_in = '{valid: start_i & ~busy_o, volume: volume_i,
                     wave: mwo_pkg::wave_e'(wave_type_i)};

  mwo_phase u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_i        (side_in),
    .sample_time_i (sample_time_i),
    .pitch_i       (pitch_i),
    .side_o        (ph_side),
    .resid_o       (ph_resid)
  );

  mwo_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .side_i  (ph_side),
    .resid_i (ph_resid),
    .side_o  (sn_side),
    .sine_o  (sn_value)
  );

  // t = floor(2*R*V / period); sawtooth is t/2
  assign tprod = 33'(rv_q[25:10]) * 33'(mwo_pkg::TriRecip);
  assign saw   = t_q[9:1];

  always_comb begin
    case (wave6_q)
      mwo_pkg::WaveSquare: nsw_d = (saw < 9'(vol6_q[7:1])) ? 8'd0 : vol6_q;
      mwo_pkg::WaveSaw:    nsw_d = saw[7:0];
      mwo_pkg::WaveTri: begin
        if (t_q < 10'(vol6_q)) begin
          nsw_d = 8'(10'(vol6_q) - t_q);
        end else begin
          nsw_d = 8'(t_q - 10'(vol6_q));
        end
      end
      default:             nsw_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    vol5_q   <= ph_side.volume;
    wave5_q  <= ph_side.wave;
    rv_q     <= 26'(ph_resid) * 26'(ph_side.volume);
    vol6_q   <= vol5_q;
    wave6_q  <= wave5_q;
    t_q      <= 10'(tprod >> mwo_pkg::TriShift);
    dly_q[0] <= nsw_d;
    for (int i = 1; i < DlyDepth; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign done_o         = sn_side.valid;
  assign sample_value_o = (sn_side.wave == mwo_pkg::WaveSine) ? sn_value
                                                              : $signed({1'b0, dly_q[DlyDepth-1]});

  `MWO_ASSERT_NXT(a_latency, start_i && !busy_o, ##(mwo_pkg::Latency - 1) done_o, "request lost")
  `MWO_ASSERT_IMP(a_no_spurious, done_o, $past(start_i && !busy_o, mwo_pkg::Latency), "spurious result")
  `MWO_ASSERT_IMP(a_nonsine_sign, done_o && sn_side.wave != mwo_pkg::WaveSine, !sample_value_o[8], "negative non-sine sample")

endmodule
`default_nettype wire
